[src/cfd_pkg.sv]
// Package: shared types and constants for the checksummed frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package cfd_pkg;
  localparam int unsigned BufDepth = 1024;

  localparam logic [1:0] CmdPush = 2'd0;
  localparam logic [1:0] CmdRead = 2'd1;
  localparam logic [1:0] CmdRel  = 2'd2;

  localparam logic [1:0] RegHead = 2'd0;
  localparam logic [1:0] RegTail = 2'd1;
  localparam logic [1:0] RegMinL = 2'd2;
  localparam logic [1:0] RegMaxL = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx;
    logic [9:0] roff;
  } cmd_t;

  typedef struct packed {
    logic        frame_ready;
    logic [7:0]  frame_command;
    logic [15:0] device_id;
    logic [10:0] frame_length;
    logic [10:0] dropped_count;
    logic [7:0]  read_data;
    logic        overflow;
  } res_t;
endpackage
`default_nettype wire

[src/cfd_front.sv]
// Front end: input beat capture and two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module cfd_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  cfd_pkg::cmd_t  in_cmd_i,
  output logic           q_valid_o,
  input  wire            q_pop_i,
  output cfd_pkg::cmd_t  q_cmd_o
);
  import cfd_pkg::*;
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[src/cfd_back.sv]
// Back end: byte buffer, frame search sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module cfd_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            q_valid_i,
  output logic           q_pop_o,
  input  cfd_pkg::cmd_t  q_cmd_i,
  input  wire [7:0]      head_i,
  input  wire [7:0]      tail_i,
  input  wire [10:0]     minl_i,
  input  wire [10:0]     maxl_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output cfd_pkg::res_t  out_res_o
);
  import cfd_pkg::*;
  localparam int unsigned AW = $clog2(BufDepth);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned PW = FW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_SKIP  = 4'd2;
  localparam logic [3:0] S_LEN1  = 4'd3;
  localparam logic [3:0] S_LEN2  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_TAIL  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_FLD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_RD    = 4'd11;

  logic [7:0] mem [BufDepth];
  logic [7:0] rd_q;
  logic [AW-1:0] raddr;
  logic          wen;
  logic [AW-1:0] waddr;

  logic [3:0] st_q;
  logic [AW-1:0] old_q;
  logic [FW-1:0] fill_q;
  logic held_q;
  logic [10:0] hlen_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] k_q;
  logic [10:0] flen_q;
  logic [7:0] sum_q, lo_q, cb_q;
  logic [1:0] fi_q;
  logic [7:0] f3_q, f4_q, f5_q;
  logic [10:0] drop_q;
  logic ovf_q;
  logic [7:0] rdat_q;
  logic [1:0] cmd_q;
  logic [9:0] roff_q;
  logic ov_q;
  res_t res;
  logic take;
  logic [15:0] cand;

  logic [PW-1:0] fillx, left;
  assign fillx = {1'b0, fill_q};
  assign left  = fillx - pos_q;
  assign cand  = {rd_q, lo_q};

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                            input logic [PW-1:0] o);
    logic [PW-1:0] s;
    s = {{(PW-AW){1'b0}}, base} + o;
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= q_cmd_i.rx;
    rd_q <= mem[raddr];
  end

  assign take  = (st_q == S_IDLE) && q_valid_i && !ov_q;
  assign waddr = addr_of(old_q, {1'b0, fill_q});
  assign wen   = take && (q_cmd_i.cmd == CmdPush) && (fill_q < FW'(BufDepth));

  // read address: pos+k during search, read offset or field offset otherwise
  always_comb begin
    raddr = addr_of(old_q, pos_q + k_q);
    if (st_q == S_IDLE || st_q == S_RD) raddr = addr_of(old_q, {{(PW-10){1'b0}}, roff_q});
    if (st_q == S_FLD) raddr = addr_of(old_q, PW'(3) + {{(PW-2){1'b0}}, fi_q});
  end

  // k_q: offset requested this cycle; rd_q holds byte for k_q-1 next cycle
  logic start_hunt;
  assign start_hunt = !held_q && (fillx >= {{(PW-11){1'b0}}, minl_i});

  logic [PW-1:0] lenx;
  assign lenx = {{(PW-11){1'b0}}, flen_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; old_q <= '0; fill_q <= '0; held_q <= 1'b0; hlen_q <= '0;
      ov_q <= 1'b0; pos_q <= '0; k_q <= '0; flen_q <= '0; sum_q <= '0;
      lo_q <= '0; cb_q <= '0; fi_q <= '0; f3_q <= '0; f4_q <= '0; f5_q <= '0;
      drop_q <= '0; ovf_q <= 1'b0; rdat_q <= '0; cmd_q <= '0; roff_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (ov_q && out_ready_i) ov_q <= 1'b0;
          if (take) begin
            cmd_q <= q_cmd_i.cmd; roff_q <= q_cmd_i.roff;
            drop_q <= '0; rdat_q <= '0; pos_q <= '0; k_q <= '0; fi_q <= '0;
            ovf_q <= (q_cmd_i.cmd == CmdPush) && (fill_q >= FW'(BufDepth));
            unique case (q_cmd_i.cmd)
              CmdPush: begin
                st_q <= S_DONE;
                if (fill_q < FW'(BufDepth)) fill_q <= fill_q + 1'b1;
              end
              CmdRead: st_q <= S_RD;
              CmdRel: begin
                if (held_q) begin
                  old_q <= addr_of(old_q, {1'b0, hlen_q});
                  fill_q <= fill_q - hlen_q[FW-1:0];
                  held_q <= 1'b0; hlen_q <= '0;
                  st_q <= S_DONE;
                end else st_q <= S_FLD;
              end
              default: st_q <= S_FLD;
            endcase
          end
        end
        S_DONE: begin
          if (start_hunt) st_q <= S_POS; else st_q <= S_FLD;
        end
        S_POS: begin
          // issue read of byte at pos
          if (pos_q >= fillx) st_q <= S_TAIL;
          else begin
            k_q <= PW'(1); st_q <= S_LEN1;
          end
        end
        S_LEN1: begin
          // rd_q = byte at pos
          if (rd_q != head_i) begin
            pos_q <= pos_q + 1'b1; k_q <= '0; st_q <= S_SKIP;
          end else if (left < PW'(3)) begin
            st_q <= S_TAIL;
          end else begin
            k_q <= PW'(2); st_q <= S_LEN2;
          end
        end
        S_LEN2: begin
          if (k_q == PW'(2)) begin
            lo_q <= rd_q; k_q <= PW'(3);
          end else begin
            flen_q <= cand[10:0];
            if (cand > {5'd0, maxl_i} || cand < {5'd0, minl_i} || cand < 16'd4 ||
                cand > 16'(BufDepth)) begin
              pos_q <= pos_q + 1'b1; k_q <= '0; st_q <= S_POS;
            end else if (left < cand[PW-1:0]) begin
              st_q <= S_TAIL;
            end else begin
              k_q <= PW'(1); sum_q <= '0; st_q <= S_SUM;
            end
          end
        end
        S_SKIP: begin
          // issue read at pos then test it
          if (pos_q >= fillx) begin
            st_q <= S_TAIL;
          end else if (k_q == '0) begin
            k_q <= PW'(1);
          end else begin
            k_q <= '0;
            if (rd_q == head_i) begin
              if (left >= {{(PW-11){1'b0}}, minl_i}) st_q <= S_POS;
              else st_q <= S_TAIL;
            end else pos_q <= pos_q + 1'b1;
          end
        end
        S_SUM: begin
          // reads at k=1..flen-2 issued; each byte reaches rd_q in the next cycle, bytes 1..flen-3 are summed
          if (k_q > PW'(1)) sum_q <= sum_q + rd_q;
          if (k_q == lenx - PW'(2)) begin
            k_q <= lenx - PW'(1); st_q <= S_CHK;
          end else k_q <= k_q + 1'b1;
        end
        S_CHK: begin
          // checksum byte arrives first, tail byte in the next cycle
          if (k_q == lenx - PW'(1)) begin
            cb_q <= rd_q; k_q <= lenx;
          end else if (rd_q != tail_i || cb_q != sum_q) begin
            pos_q <= pos_q + 1'b1; k_q <= '0; st_q <= S_POS;
          end else begin
            st_q <= S_TAIL; held_q <= 1'b1; hlen_q <= flen_q;
          end
        end
        S_TAIL: begin
          // commit discard of pos bytes
          old_q <= addr_of(old_q, pos_q);
          fill_q <= fill_q - pos_q[FW-1:0];
          drop_q <= pos_q[10:0];
          fi_q <= '0; st_q <= S_FLD;
        end
        S_RD: begin
          st_q <= S_FLD; fi_q <= '0;
        end
        S_FLD: begin
          // fi 0..2 issue, data arrives in the next cycle
          if (fi_q == 2'd0 && cmd_q == CmdRead)
            rdat_q <= (held_q && {1'b0, roff_q} < hlen_q) ? rd_q : 8'd0;
          if (fi_q == 2'd1) f3_q <= (hlen_q > 11'd3) ? rd_q : 8'd0;
          if (fi_q == 2'd2) f4_q <= (hlen_q > 11'd4) ? rd_q : 8'd0;
          if (fi_q == 2'd3) begin
            f5_q <= (hlen_q > 11'd5) ? rd_q : 8'd0; st_q <= S_OUT;
          end
          fi_q <= fi_q + 1'b1;
        end
        S_OUT: begin
          ov_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // S_FLD reads offset 3+fi; fi=0 cycle still carries read-offset data
  always_comb begin
    res.frame_ready   = held_q;
    res.frame_command = held_q ? f3_q : 8'd0;
    res.device_id     = held_q ? {f5_q, f4_q} : 16'd0;
    res.frame_length  = held_q ? hlen_q : 11'd0;
    res.dropped_count = drop_q;
    res.read_data     = rdat_q;
    res.overflow      = ovf_q;
  end

  assign q_pop_o     = take;
  assign out_valid_o = ov_q;
  assign out_res_o   = res;
endmodule
`default_nettype wire

[src/checksummed_frame_deframer.sv]
// Top level: checksummed frame deframer.
//   channel | dir | beat fields
//   s_axis  | in  | tdata: command[1:0] rx_byte[9:2] read_offset[19:10]
//   m_axis  | out | tdata: frame_ready..overflow (56 bits)
//   cfg     | in  | index[1:0] data[10:0]
// A read passes S_RD and a push with no search S_DONE before the field reads in
// S_FLD; a status beat or a release with no frame held goes straight to S_FLD.
// A search adds a discard step, a skip step per junk byte, a length read per
// head with a bad length and a read of the whole frame per checksum test; each
// failed candidate gives up one byte, and the scan resumes at the next byte.
// Reset clears pointers, flags and settings, not the byte store; a stalled
// result holds the back end while the front queue takes two more beats.
`timescale 1ns / 1ps
`default_nettype none
module checksummed_frame_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,  // command, rx_byte, read_offset, pad
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,  // ready, cmd, id, len, drop, rdata, ovf
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [10:0] cfg_data_i
);
  import cfd_pkg::*;
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop;
  logic [7:0] head_q, tail_q;
  logic [10:0] minl_q, maxl_q;

  assign in_cmd.cmd  = s_axis_tdata[1:0];
  assign in_cmd.rx   = s_axis_tdata[9:2];
  assign in_cmd.roff = s_axis_tdata[19:10];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 8'd170; tail_q <= 8'd85; minl_q <= 11'd8; maxl_q <= 11'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHead: head_q <= cfg_data_i[7:0];
        RegTail: tail_q <= cfg_data_i[7:0];
        RegMinL: minl_q <= cfg_data_i;
        RegMaxL: maxl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfd_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_cmd_i(in_cmd), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  cfd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .head_i(head_q), .tail_i(tail_q), .minl_i(minl_q), .maxl_i(maxl_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {res.overflow, res.read_data, res.dropped_count,
                         res.frame_length, res.device_id, res.frame_command,
                         res.frame_ready};
endmodule
`default_nettype wire

[tb/testbench.sv]
// Checksummed frame deframer testbench: scoreboard-checked directed and random traffic.
`timescale 1ns / 1ps
module testbench;
  import cfd_pkg::*;

  localparam int unsigned Depth = 1024;
  localparam int unsigned StallLimit = 20000;
  localparam logic [1:0] CmdNone = 2'd3;

  class deframe_scoreboard;
    logic [7:0]  ring [Depth];
    int unsigned oldest, fill, held_len;
    bit          held;
    logic [7:0]  head_val, tail_val;
    int unsigned min_len, max_len;
    logic [55:0] pending_status [$];
    int          errors;

    function new();
      oldest = 0; fill = 0; held = 0; held_len = 0;
      head_val = 8'd170; tail_val = 8'd85; min_len = 8; max_len = 1024;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        RegHead: head_val = val[7:0];
        RegTail: tail_val = val[7:0];
        RegMinL: min_len = val;
        RegMaxL: max_len = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] at(int unsigned k);
      return ring[(oldest + k) % Depth];
    endfunction

    function void drop_front(int unsigned n);
      if (n > fill) n = fill;
      oldest = (oldest + n) % Depth;
      fill -= n;
    endfunction

    function int unsigned find_frame();
      int unsigned pos, left, flen, sum;
      pos = 0;
      if (held || fill < min_len) return 0;
      forever begin
        if (pos >= fill) begin
          pos = fill;
          break;
        end
        if (at(pos) != head_val) begin
          pos++;
          while (pos < fill && at(pos) != head_val) pos++;
          if (pos < fill && fill - pos >= min_len) continue;
          break;
        end
        left = fill - pos;
        if (left < 3) break;
        flen = at(pos + 1) | (at(pos + 2) << 8);
        if (flen > max_len || flen < min_len || flen < 4 || flen > Depth) begin
          pos++;
          continue;
        end
        if (left < flen) break;
        sum = 0;
        for (int unsigned k = 1; k <= flen - 3; k++) sum += at(pos + k);
        if (at(pos + flen - 1) == tail_val && at(pos + flen - 2) == sum[7:0]) begin
          drop_front(pos);
          held = 1;
          held_len = flen;
          return pos;
        end
        pos++;
      end
      drop_front(pos);
      return pos;
    endfunction

    function logic [7:0] held_at(int unsigned off);
      if (!held || off >= held_len) return 8'd0;
      return at(off);
    endfunction

    function void note_beat(cmd_t c);
      int unsigned dropped;
      logic [7:0]  rdata;
      logic        ovf;
      dropped = 0; rdata = 0; ovf = 0;
      case (c.cmd)
        CmdPush: begin
          if (fill >= Depth) ovf = 1;
          else begin
            ring[(oldest + fill) % Depth] = c.rx;
            fill++;
          end
          dropped = find_frame();
        end
        CmdRead: rdata = held_at(c.roff);
        CmdRel: if (held) begin
          drop_front(held_len);
          held = 0;
          held_len = 0;
          dropped = find_frame();
        end
        default: ;
      endcase
      if (dropped > 2047) dropped = 2047;
      pending_status.push_back({ovf, rdata, dropped[10:0], held ? held_len[10:0] : 11'd0,
                                held_at(5), held_at(4), held_at(3), held});
    endfunction

    function void cmp(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check(logic [55:0] got);
      logic [55:0] e;
      if (pending_status.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      e = pending_status.pop_front();
      cmp("frame_ready", e[0], got[0]);
      cmp("frame_command", e[8:1], got[8:1]);
      cmp("device_id", e[24:9], got[24:9]);
      cmp("frame_length", e[35:25], got[35:25]);
      cmp("dropped_count", e[46:36], got[46:36]);
      cmp("read_data", e[54:47], got[54:47]);
      cmp("overflow", e[55], got[55]);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_valid = 0;
  logic        s_ready;
  logic [23:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 0;
  logic [55:0] m_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  deframe_scoreboard sb = new();
  int unsigned src_idle_pct = 20;
  int unsigned sink_idle_pct = 83;
  int unsigned beats_sent = 0;

  checksummed_frame_deframer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) sb.check(m_data);
      if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] rx, logic [9:0] roff);
    cmd_t c;
    c.cmd = cmd; c.rx = rx; c.roff = roff;
    if ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_valid <= 0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1;
    s_data <= {4'd0, roff, rx, cmd};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.note_beat(c);
    beats_sent++;
    if (beats_sent == 200) begin
      src_idle_pct = 83; sink_idle_pct = 20;
    end else if (beats_sent == 420) begin
      src_idle_pct = 0; sink_idle_pct = 0;
    end
  endtask

  task automatic push(logic [7:0] b);
    send(CmdPush, b, 10'($urandom));
  endtask

  task automatic push_frame(int unsigned len, bit bad_sum, bit bad_tail);
    logic [7:0] b [];
    logic [7:0] sum;
    b = new[len];
    b[0] = sb.head_val;
    b[1] = len[7:0];
    b[2] = len[15:8];
    sum = b[1];
    for (int unsigned k = 2; k <= len - 3; k++) begin
      if (k > 2) b[k] = 8'($urandom);
      sum += b[k];
    end
    b[len - 2] = bad_sum ? ~sum : sum;
    b[len - 1] = bad_tail ? ~sb.tail_val : sb.tail_val;
    foreach (b[i]) push(b[i]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_valid <= 0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int unsigned beats);
    int unsigned stop, lo, hi, len;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      if (sb.held) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(3) == 0) send(CmdRead, 8'($urandom), 10'($urandom));
          else send(CmdRead, 8'($urandom), 10'($urandom_range(0, sb.held_len + 1)));
        end
        if ($urandom_range(7) == 0) send(CmdNone, 8'($urandom), 10'($urandom));
        if ($urandom_range(5) == 0) push(8'($urandom));
        send(CmdRel, 8'($urandom), 10'($urandom));
      end else begin
        case ($urandom_range(9))
          0, 1: repeat ($urandom_range(1, 4)) push(8'($urandom));
          2: send($urandom_range(1) ? CmdRel : CmdNone, 8'($urandom), 10'($urandom));
          default: begin
            lo = sb.min_len < 6 ? 6 : sb.min_len;
            hi = lo + 20 > sb.max_len ? sb.max_len : lo + 20;
            len = hi < lo ? lo : $urandom_range(lo, hi);
            push_frame(len, $urandom_range(7) == 0, $urandom_range(9) == 0);
          end
        endcase
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed part at the default settings
    send(CmdRead, 8'h00, 10'd0);
    send(CmdRel, 8'h00, 10'd0);
    send(CmdNone, 8'hFF, 10'h3FF);
    push_frame(8, 0, 0);
    send(CmdRead, 8'h00, 10'd0);
    send(CmdRead, 8'h00, 10'd7);
    send(CmdRead, 8'h00, 10'd8);
    send(CmdRead, 8'hFF, 10'h3FF);
    send(CmdRel, 8'h00, 10'd0);
    push_frame(9, 1, 0);
    push_frame(10, 0, 1);
    push(8'd170); push(8'hD0); push(8'h07);
    repeat (8) push(8'h11);
    push(8'd170); push(8'h00);
    drain();
    beats_sent = 0;
    random_phase(125);
    write_reg(RegHead, 11'd0);
    write_reg(RegTail, 11'd255);
    write_reg(RegMinL, 11'd4);
    write_reg(RegMaxL, 11'd12);
    random_phase(125);
    write_reg(RegHead, 11'd255);
    write_reg(RegTail, 11'd0);
    write_reg(RegMinL, 11'd6);
    write_reg(RegMaxL, 11'd1024);
    random_phase(125);
    write_reg(RegHead, 11'd170);
    write_reg(RegTail, 11'd85);
    write_reg(RegMinL, 11'd8);
    write_reg(RegMaxL, 11'd40);
    random_phase(125);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[files.f]
src/cfd_pkg.sv
src/cfd_front.sv
src/cfd_back.sv
src/checksummed_frame_deframer.sv
tb/testbench.sv
